// ===== hw/rtl/tcf_pkg.sv =====
`default_nettype none

package tcf_pkg;

    // Field widths.
    localparam int GYRO_W = 19;
    localparam int ACC_W  = 16;
    localparam int ANG_W  = 19;
    localparam int OUT_W  = 20;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KAPPA   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 1'b1;

    localparam logic [CFG_W-1:0] KAPPA_RESET   = 16'd64225;
    localparam logic [CFG_W-1:0] EPSILON_RESET = 16'd66;

    // Scaling constants.
    localparam int RATE_K   = 292818;   // 256 * pi/180 * 2^16
    localparam int DT_K     = 161061;   // 0.0096 * 2^24
    localparam int INV_DT_K = 26667;    // 2^8 / 0.0096
    localparam int HALF_PI  = 102944;
    localparam int ACC_LIMIT = 205888;
    localparam int LIM_HI   = 524287;
    localparam int LIM_LO   = -524288;

    // Datapath widths.
    localparam int PROD_W = 53;
    localparam int MUL_A_W = 38;
    localparam int MUL_B_W = 20;
    localparam int WD_W   = 23;
    localparam int PRED_W = 21;
    localparam int DIFF_W = 22;
    localparam int SUM_W  = 39;
    localparam int SAT_W  = 30;

    // Rotator.
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W = $clog2(CORDIC_STEPS);
    localparam int CORD_W = 28;
    localparam int Z_W    = 20;
    localparam int TAB_N  = 24;
    localparam int TAB_IDX_W = 5;

    localparam logic [16:0] ATAN_TAB [0:TAB_N-1] = '{
        17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
        17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2,
        17'd1, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
    };

    typedef struct packed {
        logic init;
        logic step;
    } cord_ctl_t;

    typedef struct packed {
        logic                    last;
        logic signed [ANG_W-1:0] angle;
    } cord_stat_t;

    // Microcode fields.
    localparam int PC_W = 4;

    localparam logic [2:0] A_NONE  = 3'd0;
    localparam logic [2:0] A_WDIFF = 3'd1;
    localparam logic [2:0] A_PRED  = 3'd2;
    localparam logic [2:0] A_ACC   = 3'd3;
    localparam logic [2:0] A_SUMLD = 3'd4;
    localparam logic [2:0] A_FUSE  = 3'd5;
    localparam logic [2:0] A_BIAS  = 3'd6;
    localparam logic [2:0] A_OUT   = 3'd7;

    localparam logic [1:0] C_NONE = 2'd0;
    localparam logic [1:0] C_INIT = 2'd1;
    localparam logic [1:0] C_ITER = 2'd2;

    localparam logic [2:0] M_NONE  = 3'd0;
    localparam logic [2:0] M_RATE  = 3'd1;
    localparam logic [2:0] M_DT    = 3'd2;
    localparam logic [2:0] M_KPRED = 3'd3;
    localparam logic [2:0] M_KACC  = 3'd4;
    localparam logic [2:0] M_EPS   = 3'd5;
    localparam logic [2:0] M_INVDT = 3'd6;

    localparam logic [2:0] J_NEXT      = 3'd0;
    localparam logic [2:0] J_WAIT_IN   = 3'd1;
    localparam logic [2:0] J_CORD_MORE = 3'd2;
    localparam logic [2:0] J_OUT_BUSY  = 3'd3;
    localparam logic [2:0] J_ALWAYS    = 3'd4;

    localparam logic [PC_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [PC_W-1:0] STEP_LOOP = 4'd5;
    localparam logic [PC_W-1:0] STEP_BIAS = 4'd11;
    localparam logic [PC_W-1:0] STEP_OUT  = 4'd12;
    localparam logic [PC_W-1:0] STEP_LAST = 4'd13;

    typedef struct packed {
        logic [2:0]      alu;
        logic [1:0]      cord;
        logic [2:0]      mul;
        logic [2:0]      jump;
        logic [PC_W-1:0] target;
    } ucode_t;

    // The program. A taken jump loads target, otherwise the step counter advances.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t u;
        u = '{alu: A_NONE, cord: C_NONE, mul: M_NONE, jump: J_ALWAYS, target: STEP_IDLE};
        case (pc)
            4'd0:  u = '{alu: A_NONE,  cord: C_NONE, mul: M_NONE,  jump: J_WAIT_IN,
                         target: STEP_IDLE};
            4'd1:  u = '{alu: A_NONE,  cord: C_INIT, mul: M_RATE,  jump: J_NEXT,
                         target: STEP_IDLE};
            4'd2:  u = '{alu: A_WDIFF, cord: C_ITER, mul: M_NONE,  jump: J_NEXT,
                         target: STEP_IDLE};
            4'd3:  u = '{alu: A_NONE,  cord: C_ITER, mul: M_DT,    jump: J_NEXT,
                         target: STEP_IDLE};
            4'd4:  u = '{alu: A_PRED,  cord: C_ITER, mul: M_NONE,  jump: J_NEXT,
                         target: STEP_IDLE};
            4'd5:  u = '{alu: A_NONE,  cord: C_ITER, mul: M_NONE,  jump: J_CORD_MORE,
                         target: STEP_LOOP};
            4'd6:  u = '{alu: A_ACC,   cord: C_NONE, mul: M_NONE,  jump: J_NEXT,
                         target: STEP_IDLE};
            4'd7:  u = '{alu: A_NONE,  cord: C_NONE, mul: M_KPRED, jump: J_NEXT,
                         target: STEP_IDLE};
            4'd8:  u = '{alu: A_SUMLD, cord: C_NONE, mul: M_KACC,  jump: J_NEXT,
                         target: STEP_IDLE};
            4'd9:  u = '{alu: A_FUSE,  cord: C_NONE, mul: M_EPS,   jump: J_NEXT,
                         target: STEP_IDLE};
            4'd10: u = '{alu: A_NONE,  cord: C_NONE, mul: M_INVDT, jump: J_NEXT,
                         target: STEP_IDLE};
            4'd11: u = '{alu: A_BIAS,  cord: C_NONE, mul: M_NONE,  jump: J_NEXT,
                         target: STEP_IDLE};
            4'd12: u = '{alu: A_OUT,   cord: C_NONE, mul: M_NONE,  jump: J_OUT_BUSY,
                         target: STEP_OUT};
            4'd13: u = '{alu: A_NONE,  cord: C_NONE, mul: M_NONE,  jump: J_ALWAYS,
                         target: STEP_IDLE};
            default: u = '{alu: A_NONE, cord: C_NONE, mul: M_NONE, jump: J_ALWAYS,
                           target: STEP_IDLE};
        endcase
        return u;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat20(input logic signed [SAT_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_W'(LIM_HI)) begin
            r = OUT_W'(LIM_HI);
        end else if (v < SAT_W'(LIM_LO)) begin
            r = OUT_W'(LIM_LO);
        end else begin
            r = OUT_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tcf_cordic.sv =====
`default_nettype none

module tcf_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tcf_pkg::cord_ctl_t                  ctl,
    input  logic signed [tcf_pkg::ACC_W-1:0]    accel_x,
    input  logic signed [tcf_pkg::ACC_W-1:0]    accel_z,
    output tcf_pkg::cord_stat_t                 stat
);
    import tcf_pkg::*;

    logic signed [CORD_W-1:0] x_reg, x_next;
    logic signed [CORD_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic                     zero_reg, zero_next;

    logic signed [ACC_W:0]    neg_ax;
    logic signed [CORD_W-1:0] xs, ys, dx, dy;
    logic signed [Z_W-1:0]    tab_s;

    always_comb
    begin
        neg_ax = -(ACC_W+1)'(accel_x);
        xs = CORD_W'($signed({accel_z, 8'b0}));
        ys = CORD_W'($signed({neg_ax, 8'b0}));
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
        tab_s = Z_W'($signed({1'b0, ATAN_TAB[TAB_IDX_W'(iter_reg)]}));

        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        iter_next = iter_reg;
        zero_next = zero_reg;

        if (ctl.init) begin
            zero_next = (accel_x == '0) && (accel_z == '0);
            iter_next = '0;
            x_next = xs;
            y_next = ys;
            z_next = '0;
            // A vector in the left half plane is turned a quarter turn first.
            if (xs < 0) begin
                if (ys >= 0) begin
                    x_next = ys;
                    y_next = -xs;
                    z_next = Z_W'(HALF_PI);
                end else begin
                    x_next = -ys;
                    y_next = xs;
                    z_next = -Z_W'(HALF_PI);
                end
            end
        end else if (ctl.step) begin
            iter_next = iter_reg + 1'b1;
            if (y_reg >= 0) begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + tab_s;
            end else begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - tab_s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            iter_reg <= '0;
        end else begin
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        zero_reg <= zero_next;
    end

    always_comb
    begin
        stat.last = (iter_reg == ITER_W'(CORDIC_STEPS - 1));
        if (zero_reg) begin
            stat.angle = '0;
        end else if (z_reg > Z_W'(ACC_LIMIT)) begin
            stat.angle = ANG_W'(ACC_LIMIT);
        end else if (z_reg < -Z_W'(ACC_LIMIT)) begin
            stat.angle = -ANG_W'(ACC_LIMIT);
        end else begin
            stat.angle = ANG_W'(z_reg);
        end
    end

    // The iteration count restarts on every new vector.
    a_iter_init: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.init |=> iter_reg == '0)
        else $error("rotator iteration count not cleared");

    a_iter_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && !ctl.init) |=> iter_reg == $past(iter_reg) + 1'b1)
        else $error("rotator iteration count did not advance");

    a_iter_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!ctl.step && !ctl.init) |=> $stable(iter_reg))
        else $error("rotator iteration count moved while idle");

endmodule

`default_nettype wire

// ===== hw/rtl/tilt_complementary_filter_core.sv =====
`default_nettype none

// Channel  Direction  Handshake              Words
// in       input      in_valid / in_stall    gyro_rate, accel_x, accel_z
// out      output     out_valid / out_stall  accel_angle, fused_angle, bias_estimate
// cfg      input      cfg_write              cfg_index, cfg_data (kappa, epsilon)
//
// The microprogram carries each accepted word through the rotator loop and the multiplier steps to
// its output step, and does not take the next word until the last word's program is through.
// A new input word is taken only when the sequencer is back at its idle step.
// A finished result waits in the output register; a stalled output holds the
// sequencer at its output step. Reset clears the angle and bias and restores the
// register defaults; there is no clearing pass.

module tilt_complementary_filter_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tcf_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [tcf_pkg::GYRO_W-1:0]    gyro_rate,
    input  logic signed [tcf_pkg::ACC_W-1:0]     accel_x,
    input  logic signed [tcf_pkg::ACC_W-1:0]     accel_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [tcf_pkg::ANG_W-1:0]     accel_angle,
    output logic signed [tcf_pkg::OUT_W-1:0]     fused_angle,
    output logic signed [tcf_pkg::OUT_W-1:0]     bias_estimate
);
    import tcf_pkg::*;

    logic [PC_W-1:0] pc_reg, pc_next;
    ucode_t          uc;
    logic            jump_taken;
    logic            in_accept;
    logic            out_busy;
    logic            out_valid_reg, out_valid_next;

    logic [CFG_W-1:0] kappa_reg, kappa_next;
    logic [CFG_W-1:0] epsilon_reg, epsilon_next;

    logic signed [OUT_W-1:0] angle_reg, angle_next;
    logic signed [OUT_W-1:0] bias_reg, bias_next;

    logic signed [GYRO_W-1:0] g_reg;
    logic signed [ACC_W-1:0]  ax_reg, az_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [WD_W-1:0]   wd_reg;
    logic signed [PRED_W-1:0] pred_reg;
    logic signed [ANG_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [OUT_W-1:0]  fused_reg;
    logic signed [ANG_W-1:0]  acc_out_reg;
    logic signed [OUT_W-1:0]  fused_out_reg, bias_out_reg;

    logic signed [MUL_A_W-1:0]         mul_a;
    logic signed [MUL_B_W-1:0]         mul_b;
    logic signed [MUL_A_W+MUL_B_W-1:0] mul_full;
    logic signed [PROD_W-1:0]          rnd16, rnd24;
    logic signed [DIFF_W-1:0]          diff;
    logic signed [SUM_W-1:0]           sum_all, fuse_rnd;
    logic signed [SAT_W-1:0]           bias_sum;
    logic [CFG_W:0]                    kappa_inv;

    cord_ctl_t  cctl;
    cord_stat_t cstat;

    tcf_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (cctl),
        .accel_x (ax_reg),
        .accel_z (az_reg),
        .stat    (cstat)
    );

    // Sequencer.
    always_comb
    begin
        uc = ucode_rom(pc_reg);
        in_stall = (pc_reg != STEP_IDLE);
        in_accept = in_valid && !in_stall;
        out_busy = out_valid_reg && out_stall;
        case (uc.jump)
            J_NEXT:      jump_taken = 1'b0;
            J_WAIT_IN:   jump_taken = !in_valid;
            J_CORD_MORE: jump_taken = !cstat.last;
            J_OUT_BUSY:  jump_taken = out_busy;
            J_ALWAYS:    jump_taken = 1'b1;
            default:     jump_taken = 1'b1;
        endcase
        pc_next = jump_taken ? uc.target : pc_reg + 1'b1;
        cctl.init = (uc.cord == C_INIT);
        cctl.step = (uc.cord == C_ITER);
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        diff = DIFF_W'(pred_reg) - DIFF_W'(acc_reg);
        kappa_inv = (CFG_W+1)'(1 << CFG_W) - {1'b0, kappa_reg};
        case (uc.mul)
            M_RATE:
            begin
                mul_a = MUL_A_W'(g_reg);
                mul_b = MUL_B_W'(RATE_K);
            end
            M_DT:
            begin
                mul_a = MUL_A_W'(wd_reg);
                mul_b = MUL_B_W'(DT_K);
            end
            M_KPRED:
            begin
                mul_a = MUL_A_W'(pred_reg);
                mul_b = $signed(MUL_B_W'(kappa_reg));
            end
            M_KACC:
            begin
                mul_a = MUL_A_W'(acc_reg);
                mul_b = $signed(MUL_B_W'(kappa_inv));
            end
            M_EPS:
            begin
                mul_a = MUL_A_W'(diff);
                mul_b = $signed(MUL_B_W'(epsilon_reg));
            end
            M_INVDT:
            begin
                mul_a = $signed(prod_reg[MUL_A_W-1:0]);
                mul_b = MUL_B_W'(INV_DT_K);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_full = mul_a * mul_b;
    end

    // Rounding and saturation on the multiplier result, state and output-valid updates, and configuration writes.
    always_comb
    begin
        rnd16 = (prod_reg + $signed(PROD_W'(1 << 15))) >>> 16;
        rnd24 = (prod_reg + $signed(PROD_W'(1 << 23))) >>> 24;
        sum_all = sum_reg + SUM_W'(prod_reg);
        fuse_rnd = (sum_all + $signed(SUM_W'(1 << 15))) >>> 16;
        bias_sum = SAT_W'(bias_reg) + SAT_W'(rnd24);

        angle_next = angle_reg;
        bias_next = bias_reg;
        if (uc.alu == A_BIAS) begin
            angle_next = fused_reg;
            bias_next = sat20(bias_sum);
        end

        out_valid_next = out_valid_reg && out_stall;
        if (uc.alu == A_OUT && !out_busy) begin
            out_valid_next = 1'b1;
        end

        kappa_next = kappa_reg;
        epsilon_next = epsilon_reg;
        if (cfg_write) begin
            case (cfg_index)
                REG_KAPPA:   kappa_next = cfg_data;
                REG_EPSILON: epsilon_next = cfg_data;
                default:     kappa_next = kappa_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg <= STEP_IDLE;
            out_valid_reg <= 1'b0;
            kappa_reg <= KAPPA_RESET;
            epsilon_reg <= EPSILON_RESET;
            angle_reg <= '0;
            bias_reg <= '0;
        end else begin
            pc_reg <= pc_next;
            out_valid_reg <= out_valid_next;
            kappa_reg <= kappa_next;
            epsilon_reg <= epsilon_next;
            angle_reg <= angle_next;
            bias_reg <= bias_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            g_reg <= gyro_rate;
            ax_reg <= accel_x;
            az_reg <= accel_z;
        end
        if (uc.mul != M_NONE) begin
            prod_reg <= $signed(mul_full[PROD_W-1:0]);
        end
        case (uc.alu)
            A_WDIFF: wd_reg <= WD_W'(rnd16) - WD_W'(bias_reg);
            A_PRED:  pred_reg <= PRED_W'(angle_reg) + PRED_W'(rnd24);
            A_ACC:   acc_reg <= cstat.angle;
            A_SUMLD: sum_reg <= SUM_W'(prod_reg);
            A_FUSE:  fused_reg <= sat20(SAT_W'(fuse_rnd));
            A_OUT:
            begin
                if (!out_busy) begin
                    acc_out_reg <= acc_reg;
                    fused_out_reg <= angle_reg;
                    bias_out_reg <= bias_reg;
                end
            end
            default: sum_reg <= sum_reg;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign accel_angle = acc_out_reg;
    assign fused_angle = fused_out_reg;
    assign bias_estimate = bias_out_reg;

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> pc_reg == STEP_IDLE + 1'b1)
        else $error("accepted word did not start the program");

    a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pc_reg) == STEP_OUT)
        else $error("result raised outside the output step");

    a_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_LOOP && cstat.last) |=> pc_reg == STEP_LOOP + 1'b1)
        else $error("rotator loop did not exit on its last step");

    a_state_update: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg != STEP_BIAS) |=> ($stable(angle_reg) && $stable(bias_reg)))
        else $error("filter state changed outside the update step");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= STEP_LAST)
        else $error("step counter left the program");

endmodule

`default_nettype wire
